/* hdl/nibble_masked_pattern_search_unit_assert.svh */
// assertion macros for the nibble masked pattern search unit
// no dependencies; included by the modules that check their own logic
`ifndef NIBBLE_MASKED_PATTERN_SEARCH_UNIT_ASSERT_SVH
`define NIBBLE_MASKED_PATTERN_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTH
`define NMPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nmps assertion failed");
`define NMPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nmps assertion failed");
`else
`define NMPS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NMPS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/nmps_pkg.sv */
// types and constants of the nibble masked pattern search unit
// no dependencies; used by every module of the unit
package nmps_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W = 5;

  localparam logic [7:0] NIB_HI = 8'hf0;
  localparam logic [7:0] NIB_LO = 8'h0f;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LO = 3'd0,
    CFG_PATTERN_HI = 3'd1,
    CFG_MASK_LO    = 3'd2,
    CFG_MASK_HI    = 3'd3,
    CFG_LENGTH     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_offset;
    logic [31:0] match_total;
    logic        buffer_done;
  } out_beat_t;

endpackage

/* hdl/nmps_cell.sv */
// one compare cell: checks one pattern byte and passes a partial-match flag on
// depends on nmps_pkg
module nmps_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       last_byte,
  input  logic [7:0] data_byte,
  input  logic [7:0] pat_byte,
  input  logic [7:0] mask_byte,
  input  logic       prev_flag,
  output logic       hit,
  output logic       flag
);

  logic hi_ok;
  logic lo_ok;

  assign hi_ok = ((mask_byte & nmps_pkg::NIB_HI) == 8'h00) ||
                 ((data_byte & nmps_pkg::NIB_HI) == (pat_byte & nmps_pkg::NIB_HI));
  assign lo_ok = ((mask_byte & nmps_pkg::NIB_LO) == 8'h00) ||
                 ((data_byte & nmps_pkg::NIB_LO) == (pat_byte & nmps_pkg::NIB_LO));
  assign hit = prev_flag && hi_ok && lo_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (fire) begin
      flag <= hit && !last_byte;
    end
  end

endmodule

/* hdl/nmps_out_buf.sv */
// two-entry output buffer that lets the input side run while a result waits
// depends on nmps_pkg and the assertion header
`include "nibble_masked_pattern_search_unit_assert.svh"
module nmps_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  nmps_pkg::out_beat_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output nmps_pkg::out_beat_t rd_data
);

  nmps_pkg::out_beat_t skid_data;
  logic                skid_valid;
  logic                rd_fire;

  assign wr_ready = !skid_valid;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (rd_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (wr_valid) begin
      if (rd_valid && !rd_ready) begin
        skid_valid <= 1'b1;
      end else begin
        rd_valid <= 1'b1;
      end
    end else if (rd_fire) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (rd_fire) begin
        rd_data <= skid_data;
      end
    end else if (wr_valid) begin
      if (rd_valid && !rd_ready) begin
        skid_data <= wr_data;
      end else begin
        rd_data <= wr_data;
      end
    end
  end

  `NMPS_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, rd_valid)
  `NMPS_ASSERT_NXT(a_skid_drains, clk, rst, skid_valid && rd_ready, !skid_valid && rd_valid)
  `NMPS_ASSERT_NXT(a_stall_fills_skid, clk, rst,
                   wr_valid && wr_ready && rd_valid && !rd_ready, skid_valid)

endmodule

/* hdl/nibble_masked_pattern_search_unit.sv */
// Masked byte-pattern search over a byte stream, one byte per beat on the input
// channel and one result beat per input beat. A new byte is taken every cycle while
// in_ready is high: a row of PATTERN_MAX cells, one per pattern byte, each compares
// the incoming byte against its pattern byte under the nibble mask and hands a
// partial-match flag to the next cell, so the result is computed in the cycle its
// byte is accepted and is registered into the output buffer. A two-entry output
// buffer keeps the input side running for one beat while a result waits; after
// that the input stalls until the output drains. Configuration writes are always
// accepted and must only happen while the unit is idle. After a beat with
// last_byte set, the offset, count and match flags clear for the next buffer.
// depends on nmps_pkg, nmps_cell, nmps_out_buf and the assertion header
`include "nibble_masked_pattern_search_unit_assert.svh"
module nibble_masked_pattern_search_unit #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  nmps_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output nmps_pkg::out_beat_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nmps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nmps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [63:0]                  pattern_lo;
  logic [63:0]                  pattern_hi;
  logic [63:0]                  mask_lo;
  logic [63:0]                  mask_hi;
  logic [nmps_pkg::LEN_W-1:0]   pattern_length;
  logic [31:0]                  byte_offset;
  logic [31:0]                  match_counter;

  logic [PATTERN_MAX-1:0]       flag;
  logic [PATTERN_MAX-1:0]       hit;
  logic [nmps_pkg::LEN_W-1:0]   len_m1;
  logic [IW-1:0]                idx_sel;
  logic                         fire;
  logic                         found;
  nmps_pkg::out_beat_t          result;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_lo     <= '0;
      pattern_hi     <= '0;
      mask_lo        <= '0;
      mask_hi        <= '0;
      pattern_length <= nmps_pkg::LEN_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        nmps_pkg::CFG_PATTERN_LO: pattern_lo <= cfg_data;
        nmps_pkg::CFG_PATTERN_HI: pattern_hi <= cfg_data;
        nmps_pkg::CFG_MASK_LO:    mask_lo <= cfg_data;
        nmps_pkg::CFG_MASK_HI:    mask_hi <= cfg_data;
        nmps_pkg::CFG_LENGTH:     pattern_length <= cfg_data[nmps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
      logic [7:0] pat_b;
      logic [7:0] mask_b;
      logic       prev;
      if (gi < 8) begin : g_lo
        assign pat_b  = pattern_lo[8*gi +: 8];
        assign mask_b = mask_lo[8*gi +: 8];
      end else if (gi < 16) begin : g_hi
        assign pat_b  = pattern_hi[8*(gi-8) +: 8];
        assign mask_b = mask_hi[8*(gi-8) +: 8];
      end else begin : g_none
        assign pat_b  = 8'h00;
        assign mask_b = 8'h00;
      end
      if (gi == 0) begin : g_head
        assign prev = 1'b1;
      end else begin : g_link
        assign prev = flag[gi-1];
      end
      nmps_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .fire      (fire),
        .last_byte (in_data.last_byte),
        .data_byte (in_data.data_byte),
        .pat_byte  (pat_b),
        .mask_byte (mask_b),
        .prev_flag (prev),
        .hit       (hit[gi]),
        .flag      (flag[gi])
      );
    end
  endgenerate

  always_comb begin
    len_m1 = pattern_length - nmps_pkg::LEN_W'(1);
    if (int'(len_m1) > PATTERN_MAX - 1) begin
      idx_sel = IW'(PATTERN_MAX - 1);
    end else begin
      idx_sel = IW'(len_m1);
    end
    found = (pattern_length != '0) && hit[idx_sel];
    result.match_found  = found;
    result.match_offset = found ? (byte_offset - 32'(idx_sel)) : 32'd0;
    result.match_total  = match_counter + 32'(found);
    result.buffer_done  = in_data.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      match_counter <= '0;
    end else if (fire) begin
      if (in_data.last_byte) begin
        byte_offset   <= '0;
        match_counter <= '0;
      end else begin
        byte_offset   <= byte_offset + 32'd1;
        match_counter <= result.match_total;
      end
    end
  end

  nmps_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fire),
    .wr_ready (in_ready),
    .wr_data  (result),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (out_data)
  );

  `NMPS_ASSERT_NXT(a_last_clears_flags, clk, rst, fire && in_data.last_byte, flag == '0)
  `NMPS_ASSERT_NXT(a_last_clears_count, clk, rst, fire && in_data.last_byte,
                   byte_offset == 32'd0 && match_counter == 32'd0)
  `NMPS_ASSERT_NXT(a_offset_steps, clk, rst, fire && !in_data.last_byte,
                   byte_offset == $past(byte_offset) + 32'd1)
  `NMPS_ASSERT_NXT(a_idle_holds, clk, rst, !fire, $stable(byte_offset) && $stable(flag))

endmodule

/* dv/tb.sv */
// testbench for nibble_masked_pattern_search_unit: directed and random byte buffers under
// varying patterns, nibble masks, lengths and handshake stalls, every result beat checked
// against a search predictor kept here; depends on nmps_pkg and the unit rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_SHOWN = 10;
  localparam int IDLE_PCT = 52;
  localparam int BOTH_PCT = 19;
  localparam int PHASE_BYTES = 220;
  localparam int NUM_PHASES = 8;

  typedef enum int {MASK_FULL, MASK_RANDOM, MASK_SPARSE, MASK_NONE} mask_style_e;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  nmps_pkg::in_beat_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  nmps_pkg::out_beat_t             out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [nmps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nmps_pkg::CFG_DATA_W-1:0] cfg_data;

  // search predictor state
  logic [63:0]                pat_lo, pat_hi, msk_lo, msk_hi;
  logic [nmps_pkg::LEN_W-1:0] len_cfg;
  logic [7:0]                 win [WIN_DEPTH];
  logic [31:0]                byte_pos;
  logic [31:0]                hit_count;
  int unsigned                fill;

  nmps_pkg::out_beat_t expected_q[$];
  int        fail_count;
  int        cycle_count;
  int        bytes_sent;
  int        send_idle_pct;
  int        recv_stall_pct;

  nibble_masked_pattern_search_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [7:0] pattern_byte(int i);
    logic [127:0] all;
    all = {pat_hi, pat_lo};
    return all[8*i +: 8];
  endfunction

  function automatic logic [7:0] mask_byte(int i);
    logic [127:0] all;
    all = {msk_hi, msk_lo};
    return all[8*i +: 8];
  endfunction

  function automatic void clear_search();
    foreach (win[k]) win[k] = 8'h00;
    byte_pos = '0;
    hit_count = '0;
    fill = 0;
  endfunction

  function automatic void reset_search_model();
    pat_lo = '0;
    pat_hi = '0;
    msk_lo = '0;
    msk_hi = '0;
    len_cfg = nmps_pkg::LEN_W'(1);
    clear_search();
  endfunction

  function automatic void apply_reg(logic [nmps_pkg::CFG_IDX_W-1:0] idx,
                                    logic [nmps_pkg::CFG_DATA_W-1:0] v);
    case (nmps_pkg::cfg_reg_e'(idx))
      nmps_pkg::CFG_PATTERN_LO: pat_lo = v;
      nmps_pkg::CFG_PATTERN_HI: pat_hi = v;
      nmps_pkg::CFG_MASK_LO:    msk_lo = v;
      nmps_pkg::CFG_MASK_HI:    msk_hi = v;
      nmps_pkg::CFG_LENGTH:     len_cfg = v[nmps_pkg::LEN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic nmps_pkg::out_beat_t search_step(nmps_pkg::in_beat_t b);
    nmps_pkg::out_beat_t r;
    int unsigned len;
    logic [7:0]  wb, pb, mb;
    logic        hit;
    len = (len_cfg > WIN_DEPTH) ? WIN_DEPTH : len_cfg;
    for (int k = WIN_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b.data_byte;
    if (fill < WIN_DEPTH) fill++;
    hit = (len != 0) && (fill >= len);
    for (int k = 0; k < len; k++) begin
      wb = win[len-1-k];
      pb = pattern_byte(k);
      mb = mask_byte(k);
      if ((mb & nmps_pkg::NIB_HI) != 0 && (wb & nmps_pkg::NIB_HI) != (pb & nmps_pkg::NIB_HI))
        hit = 1'b0;
      if ((mb & nmps_pkg::NIB_LO) != 0 && (wb & nmps_pkg::NIB_LO) != (pb & nmps_pkg::NIB_LO))
        hit = 1'b0;
    end
    r.match_found = hit;
    r.match_offset = hit ? byte_pos - (len - 1) : '0;
    if (hit) hit_count++;
    r.match_total = hit_count;
    r.buffer_done = b.last_byte;
    byte_pos++;
    if (b.last_byte) clear_search();
    return r;
  endfunction

  function automatic void check_result(nmps_pkg::out_beat_t got);
    nmps_pkg::out_beat_t want;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_SHOWN)
        $display("%0t unexpected result beat: found=%0b offset=%0d total=%0d done=%0b",
                 $time, got.match_found, got.match_offset, got.match_total, got.buffer_done);
    end else begin
      want = expected_q.pop_front();
      if (got.match_found !== want.match_found || got.match_offset !== want.match_offset ||
          got.match_total !== want.match_total || got.buffer_done !== want.buffer_done) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("%0t mismatch: expected found=%0b offset=%0d total=%0d done=%0b, got %s",
                   $time, want.match_found, want.match_offset, want.match_total,
                   want.buffer_done,
                   $sformatf("found=%0b offset=%0d total=%0d done=%0b", got.match_found,
                             got.match_offset, got.match_total, got.buffer_done));
      end
    end
  endfunction

  // predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) expected_q.push_back(search_step(in_data));
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_byte(logic [7:0] d, logic lst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.data_byte = d;
    in_data.last_byte = lst;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(nmps_pkg::cfg_reg_e idx, logic [nmps_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = IDLE_PCT;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = IDLE_PCT;
      end
      default: begin
        send_idle_pct = BOTH_PCT;
        recv_stall_pct = BOTH_PCT;
      end
    endcase
  endtask

  // power-on registers: length one, mask zero, so every byte matches
  task automatic test_reset_values();
    set_idle(IDLE_NONE);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_zero_length();
    wait_drained();
    write_reg(nmps_pkg::CFG_LENGTH, '0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  // high nibble only, low nibble only, full byte; short prefix cannot match
  task automatic test_nibble_masks();
    wait_drained();
    write_reg(nmps_pkg::CFG_PATTERN_LO, 64'h0000_0000_00ff_5aa5);
    write_reg(nmps_pkg::CFG_MASK_LO, 64'h0000_0000_00ff_0ff0);
    write_reg(nmps_pkg::CFG_LENGTH, nmps_pkg::CFG_DATA_W'(3));
    send_byte(8'ha7, 1'b0);
    send_byte(8'h3a, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'haf, 1'b1);
  endtask

  // length above the window depth is clamped, full window of extreme bytes
  task automatic test_full_window();
    wait_drained();
    write_reg(nmps_pkg::CFG_PATTERN_LO, '1);
    write_reg(nmps_pkg::CFG_PATTERN_HI, '0);
    write_reg(nmps_pkg::CFG_MASK_LO, '1);
    write_reg(nmps_pkg::CFG_MASK_HI, '1);
    write_reg(nmps_pkg::CFG_LENGTH, nmps_pkg::CFG_DATA_W'(31));
    repeat (8) send_byte(8'hff, 1'b0);
    repeat (7) send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic random_setup(logic [nmps_pkg::LEN_W-1:0] len, mask_style_e style);
    logic [63:0] m [2];
    for (int j = 0; j < 2; j++) begin
      case (style)
        MASK_FULL:   m[j] = '1;
        MASK_RANDOM: m[j] = {$urandom, $urandom};
        MASK_SPARSE: begin
          for (int n = 0; n < 16; n++)
            m[j][4*n +: 4] = $urandom_range(1) ? 4'($urandom_range(1, 15)) : 4'h0;
        end
        default:     m[j] = '0;
      endcase
    end
    write_reg(nmps_pkg::CFG_PATTERN_LO, {$urandom, $urandom});
    write_reg(nmps_pkg::CFG_PATTERN_HI, {$urandom, $urandom});
    write_reg(nmps_pkg::CFG_MASK_LO, m[0]);
    write_reg(nmps_pkg::CFG_MASK_HI, m[1]);
    write_reg(nmps_pkg::CFG_LENGTH, nmps_pkg::CFG_DATA_W'(len));
  endtask

  // buffer of random bytes with embedded, sometimes corrupted, pattern copies
  task automatic send_random_buffer();
    logic [7:0] bq[$];
    logic [7:0] b, pb, mb;
    int         n, eff, j;
    eff = (len_cfg > WIN_DEPTH) ? WIN_DEPTH : len_cfg;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 48);
    while (bq.size() < n) begin
      if (eff != 0 && $urandom_range(2) == 0) begin
        for (int k = 0; k < eff; k++) begin
          pb = pattern_byte(k);
          mb = mask_byte(k);
          b = 8'($urandom);
          if ((mb & nmps_pkg::NIB_HI) != 0)
            b = (b & nmps_pkg::NIB_LO) | (pb & nmps_pkg::NIB_HI);
          if ((mb & nmps_pkg::NIB_LO) != 0)
            b = (b & nmps_pkg::NIB_HI) | (pb & nmps_pkg::NIB_LO);
          bq.push_back(b);
        end
        if ($urandom_range(4) == 0) begin
          j = bq.size() - 1 - $urandom_range(eff - 1);
          bq[j] = bq[j] ^ 8'($urandom_range(1, 255));
        end
      end else if ($urandom_range(1) == 0) begin
        bq.push_back(pattern_byte($urandom_range(WIN_DEPTH - 1)));
      end else begin
        bq.push_back(8'($urandom));
      end
    end
    foreach (bq[k]) send_byte(bq[k], k == bq.size() - 1);
  endtask

  task automatic test_random_phase(int phase);
    int          phase_len [NUM_PHASES] = '{4, 16, 1, 0, 7, 31, 2, 12};
    mask_style_e styles [4] = '{MASK_FULL, MASK_RANDOM, MASK_SPARSE, MASK_NONE};
    idle_mode_e  modes [4] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    int          start;
    wait_drained();
    set_idle(modes[phase % 4]);
    random_setup(nmps_pkg::LEN_W'(phase_len[phase]), styles[phase % 4]);
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      send_random_buffer();
      if ($urandom_range(29) == 0) wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_ready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    bytes_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    reset_search_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_values();
    test_zero_length();
    test_nibble_masks();
    test_full_window();
    for (int p = 0; p < NUM_PHASES; p++) test_random_phase(p);
    wait_drained();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
